// ===== rtl/jte_pkg.sv =====
// Job table engine: shared constants, codes and controller/datapath interface types.
// Used by every module of the block except jte_ram, and by the port checker.
package jte_pkg;

    // Table geometry
    localparam int JOBS   = 16;
    localparam int PROCS  = 8;
    localparam int DEPTH  = JOBS * PROCS;
    localparam int SLOT_W = $clog2(JOBS);
    localparam int JW     = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int FW     = $clog2(PROCS + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(JOBS + 1);

    // Field widths
    localparam int OP_W   = 3;
    localparam int STS_W  = 3;
    localparam int ID_W   = 16;
    localparam int GRP_W  = 22;
    localparam int CNT_W  = 4;
    localparam int ST_W   = 2;
    localparam int SLOT_O = 4;
    localparam int DONE_W = 5;
    localparam int MEM_W  = GRP_W + 1;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 64;

    localparam logic [ID_W-1:0] MAX_ID = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD,
        OP_ADD_MEMBER,
        OP_FIND_ID,
        OP_FIND_MEMBER,
        OP_REMOVE_MEMBER,
        OP_DELETE,
        OP_ENQUEUE_DONE
    } op_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_TOO_MANY,
        ST_NOT_FOUND,
        ST_IDS_OUT,
        ST_QUEUE_FULL
    } status_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FREE,
        FSM_CURSOR,
        FSM_MSCAN,
        FSM_MTAIL,
        FSM_RSCAN,
        FSM_RTAIL,
        FSM_RESULT
    } fsm_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic slot_step;
        logic sel_free;
        logic sel_cursor;
        logic mem_issue;
        logic mem_check;
        logic commit;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_match;
        logic            slot_last;
        logic            mem_hit;
        logic            issue_last;
        logic            out_free;
    } stat_t;

endpackage

// ===== rtl/jte_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module jte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [$clog2(DEPTH)-1:0]       waddr,
    input  logic [WIDTH-1:0]               wdata,
    input  logic                           re,
    input  logic [$clog2(DEPTH)-1:0]       raddr,
    output logic [WIDTH-1:0]               rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/jte_datapath.sv =====
// Job table datapath: slot table, member store, search pipeline, done counter, result register.
// Depends on jte_pkg and jte_ram; sequenced by jte_controller.
module jte_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  jte_pkg::cmd_t               cmd,
    output jte_pkg::stat_t              stat,
    input  logic [jte_pkg::OP_W-1:0]    in_op,
    input  logic [jte_pkg::ID_W-1:0]    in_job_id,
    input  logic [jte_pkg::GRP_W-1:0]   in_group_id,
    input  logic [jte_pkg::GRP_W-1:0]   in_member_id,
    input  logic [jte_pkg::CNT_W-1:0]   in_proc_count,
    input  logic [jte_pkg::ST_W-1:0]    in_init_state,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [jte_pkg::STS_W-1:0]   out_status,
    output logic [jte_pkg::ID_W-1:0]    out_job_id,
    output logic [jte_pkg::SLOT_O-1:0]  out_slot,
    output logic [jte_pkg::GRP_W-1:0]   out_group,
    output logic [jte_pkg::CNT_W-1:0]   out_count,
    output logic [jte_pkg::CNT_W-1:0]   out_remaining,
    output logic [jte_pkg::ST_W-1:0]    out_state,
    output logic [jte_pkg::DONE_W-1:0]  out_done
);
    import jte_pkg::*;

    // Captured item
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   jid_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [GRP_W-1:0]  pid_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ST_W-1:0]   st_reg;

    // Slot table
    logic              valid_reg  [JOBS];
    logic [ID_W-1:0]   id_reg     [JOBS];
    logic [GRP_W-1:0]  grp_tab_reg[JOBS];
    logic [CNT_W-1:0]  cnt_tab_reg[JOBS];
    logic [CNT_W-1:0]  rem_tab_reg[JOBS];
    logic [ST_W-1:0]   st_tab_reg [JOBS];
    logic [FW-1:0]     filled_reg [JOBS];

    // Search state
    logic [SLOT_W-1:0] scan_reg;
    logic [JW-1:0]     j_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic              max_valid_reg;
    logic [ID_W-1:0]   max_reg;
    logic              id_hit_reg;
    logic              mem_hit_reg;
    logic [JW-1:0]     hit_j_reg;
    logic              rd_vld_reg;
    logic [SLOT_W-1:0] rd_slot_reg;
    logic [JW-1:0]     rd_j_reg;

    // Pending add and done queue
    logic              pend_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [JW-1:0]     cur_k_reg;
    logic [FILL_W-1:0] fill_reg;

    // Result register
    logic              out_valid_reg;
    logic [STS_W-1:0]  out_status_reg;
    logic [ID_W-1:0]   out_job_id_reg;
    logic [SLOT_O-1:0] out_slot_reg;
    logic [GRP_W-1:0]  out_group_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [CNT_W-1:0]  out_rem_reg;
    logic [ST_W-1:0]   out_state_reg;
    logic [DONE_W-1:0] out_done_reg;

    // Current slot view
    logic              cur_valid;
    logic [ID_W-1:0]   cur_id;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  cur_rem;
    logic [FW-1:0]     cur_filled;
    logic              slot_last;
    logic              j_last;
    logic              issue_qual;
    logic              mem_hit;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              ram_we;
    logic [MEM_W-1:0]  ram_wdata;
    logic [MEM_W-1:0]  ram_q;

    // Commit decode
    status_t           res_status;
    logic [ID_W-1:0]   r_id;
    logic [SLOT_O-1:0] r_slot;
    logic [GRP_W-1:0]  r_grp;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [ST_W-1:0]   r_st;
    logic [FILL_W-1:0] fill_next;
    logic              do_add;
    logic              do_addmem;
    logic              do_remove;
    logic              do_delete;
    logic [FW-1:0]     k_next;
    logic              fill_done;

    assign cur_valid  = valid_reg[scan_reg];
    assign cur_id     = id_reg[scan_reg];
    assign cur_cnt    = cnt_tab_reg[scan_reg];
    assign cur_rem    = rem_tab_reg[scan_reg];
    assign cur_filled = filled_reg[scan_reg];
    assign slot_last  = (scan_reg == SLOT_W'(JOBS - 1));
    assign j_last     = (j_reg == JW'(PROCS - 1));
    // only entries written since the add can hold a member
    assign issue_qual = cur_valid && (FW'(j_reg) < cur_filled);
    assign base       = ADDR_W'(scan_reg) * ADDR_W'(PROCS);
    assign rd_addr    = base + ADDR_W'(j_reg);
    assign mem_hit    = rd_vld_reg && (ram_q == {1'b1, pid_reg});

    assign stat.op         = op_reg;
    assign stat.id_match   = cur_valid && (cur_id == jid_reg);
    assign stat.slot_last  = slot_last;
    assign stat.mem_hit    = mem_hit;
    assign stat.issue_last = j_last && ((op_reg != OP_FIND_MEMBER) || slot_last);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign k_next    = FW'(cur_k_reg) + FW'(1);
    assign fill_done = (int'(k_next) >= int'(cur_cnt)) || (int'(k_next) >= PROCS);

    // Outcome of the item at commit
    always_comb begin
        res_status = ST_OK;
        r_id       = cur_id;
        r_slot     = SLOT_O'(scan_reg);
        r_grp      = grp_tab_reg[scan_reg];
        r_cnt      = cur_cnt;
        r_rem      = cur_rem;
        r_st       = st_tab_reg[scan_reg];
        fill_next  = fill_reg;
        do_add     = 1'b0;
        do_addmem  = 1'b0;
        do_remove  = 1'b0;
        do_delete  = 1'b0;
        case (op_reg)
            OP_ADD: begin
                if (!free_found_reg) begin
                    res_status = ST_FULL;
                end else if (int'(cnt_reg) > PROCS) begin
                    res_status = ST_TOO_MANY;
                end else if (max_valid_reg && (max_reg == MAX_ID)) begin
                    res_status = ST_IDS_OUT;
                end else begin
                    do_add = 1'b1;
                    r_id   = max_valid_reg ? max_reg + ID_W'(1) : '0;
                    r_grp  = grp_reg;
                    r_cnt  = cnt_reg;
                    r_rem  = cnt_reg;
                    r_st   = st_reg;
                end
            end
            OP_ADD_MEMBER: begin
                if (!pend_reg) res_status = ST_NOT_FOUND;
                else           do_addmem  = 1'b1;
            end
            OP_FIND_ID: begin
                if (!id_hit_reg) res_status = ST_NOT_FOUND;
            end
            OP_FIND_MEMBER: begin
                if (!mem_hit_reg) res_status = ST_NOT_FOUND;
            end
            OP_REMOVE_MEMBER: begin
                if (!mem_hit_reg) begin
                    res_status = ST_NOT_FOUND;
                end else begin
                    do_remove = 1'b1;
                    r_rem     = (cur_rem != '0) ? cur_rem - CNT_W'(1) : '0;
                end
            end
            OP_DELETE: begin
                if (!id_hit_reg) res_status = ST_NOT_FOUND;
                else             do_delete  = 1'b1;
            end
            OP_ENQUEUE_DONE: begin
                if (int'(fill_reg) >= JOBS) begin
                    res_status = ST_QUEUE_FULL;
                end else begin
                    fill_next = fill_reg + FILL_W'(1);
                    r_id      = jid_reg;
                    r_grp     = grp_reg;
                    r_slot    = '0;
                    r_cnt     = '0;
                    r_rem     = '0;
                    r_st      = '0;
                end
            end
            default: res_status = ST_NOT_FOUND;
        endcase
        if (res_status != ST_OK) begin
            r_id   = '0;
            r_slot = '0;
            r_grp  = '0;
            r_cnt  = '0;
            r_rem  = '0;
            r_st   = '0;
        end
    end

    // Member store write: fill on add member, clear on remove
    assign ram_we    = cmd.commit && (do_addmem || do_remove);
    assign ram_wdata = do_addmem ? {1'b1, pid_reg} : '0;
    assign wr_addr   = base + ADDR_W'(do_addmem ? cur_k_reg : hit_j_reg);

    jte_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_members (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (ram_wdata),
        .re    (cmd.mem_issue),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < JOBS; i++) valid_reg[i] <= 1'b0;
            pend_reg       <= 1'b0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
            rd_vld_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            max_valid_reg  <= 1'b0;
            id_hit_reg     <= 1'b0;
            mem_hit_reg    <= 1'b0;
            scan_reg       <= '0;
            j_reg          <= '0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;

            // member read pipeline
            rd_vld_reg <= cmd.mem_issue && issue_qual;
            if (cmd.mem_issue) begin
                rd_slot_reg <= scan_reg;
                rd_j_reg    <= j_reg;
                j_reg       <= j_last ? '0 : j_reg + JW'(1);
                if (j_last && (op_reg == OP_FIND_MEMBER)) scan_reg <= scan_reg + SLOT_W'(1);
            end

            if (cmd.load) begin
                op_reg         <= in_op;
                jid_reg        <= in_job_id;
                grp_reg        <= in_group_id;
                pid_reg        <= in_member_id;
                cnt_reg        <= in_proc_count;
                st_reg         <= in_init_state;
                scan_reg       <= '0;
                j_reg          <= '0;
                free_found_reg <= 1'b0;
                max_valid_reg  <= 1'b0;
                id_hit_reg     <= 1'b0;
                mem_hit_reg    <= 1'b0;
                rd_vld_reg     <= 1'b0;
            end

            // slot scan: free slot, largest id, id match
            if (cmd.slot_step) begin
                if (cur_valid) begin
                    if (!max_valid_reg || (cur_id > max_reg)) begin
                        max_reg       <= cur_id;
                        max_valid_reg <= 1'b1;
                    end
                end else if (!free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_slot_reg  <= scan_reg;
                end
                if ((op_reg != OP_ADD) && stat.id_match) id_hit_reg <= 1'b1;
                else                                     scan_reg   <= scan_reg + SLOT_W'(1);
            end

            if (cmd.sel_free)   scan_reg <= free_slot_reg;
            if (cmd.sel_cursor) scan_reg <= cur_slot_reg;

            if (cmd.mem_check && mem_hit) begin
                mem_hit_reg <= 1'b1;
                hit_j_reg   <= rd_j_reg;
                if (op_reg == OP_FIND_MEMBER) scan_reg <= rd_slot_reg;
            end

            // apply the item and load the result
            if (cmd.commit) begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status;
                out_job_id_reg <= r_id;
                out_slot_reg   <= r_slot;
                out_group_reg  <= r_grp;
                out_count_reg  <= r_cnt;
                out_rem_reg    <= r_rem;
                out_state_reg  <= r_st;
                out_done_reg   <= DONE_W'(fill_next);
                fill_reg       <= fill_next;
                if (do_add) begin
                    valid_reg[scan_reg]   <= 1'b1;
                    id_reg[scan_reg]      <= r_id;
                    grp_tab_reg[scan_reg] <= grp_reg;
                    cnt_tab_reg[scan_reg] <= cnt_reg;
                    rem_tab_reg[scan_reg] <= cnt_reg;
                    st_tab_reg[scan_reg]  <= st_reg;
                    filled_reg[scan_reg]  <= '0;
                    pend_reg              <= (cnt_reg != '0);
                    cur_slot_reg          <= scan_reg;
                    cur_k_reg             <= '0;
                end
                if (do_addmem) begin
                    filled_reg[scan_reg] <= k_next;
                    if (fill_done) pend_reg  <= 1'b0;
                    else           cur_k_reg <= cur_k_reg + JW'(1);
                end
                if (do_remove) begin
                    rem_tab_reg[scan_reg] <= r_rem;
                end
                if (do_delete) begin
                    valid_reg[scan_reg]   <= 1'b0;
                    id_reg[scan_reg]      <= '0;
                    grp_tab_reg[scan_reg] <= '0;
                    cnt_tab_reg[scan_reg] <= '0;
                    rem_tab_reg[scan_reg] <= '0;
                    st_tab_reg[scan_reg]  <= '0;
                    if (pend_reg && (cur_slot_reg == scan_reg)) pend_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_job_id    = out_job_id_reg;
    assign out_slot      = out_slot_reg;
    assign out_group     = out_group_reg;
    assign out_count     = out_count_reg;
    assign out_remaining = out_rem_reg;
    assign out_state     = out_state_reg;
    assign out_done      = out_done_reg;

endmodule

// ===== rtl/jte_controller.sv =====
// Job table controller: sequences slot scans, member searches and the commit of each item.
// Depends on jte_pkg; drives jte_datapath through cmd_t and reads stat_t.
module jte_controller (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [jte_pkg::OP_W-1:0] in_op,
    output jte_pkg::cmd_t            cmd,
    input  jte_pkg::stat_t           stat
);
    import jte_pkg::*;

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    case (in_op) inside
                        OP_ADD, OP_FIND_ID, OP_REMOVE_MEMBER, OP_DELETE: state_next = FSM_SCAN;
                        OP_ADD_MEMBER:  state_next = FSM_CURSOR;
                        OP_FIND_MEMBER: state_next = FSM_MSCAN;
                        default:        state_next = FSM_RESULT;
                    endcase
                end
            end
            // one slot per cycle
            FSM_SCAN: begin
                cmd.slot_step = 1'b1;
                if ((stat.op != OP_ADD) && stat.id_match) begin
                    state_next = (stat.op == OP_REMOVE_MEMBER) ? FSM_RSCAN : FSM_RESULT;
                end else if (stat.slot_last) begin
                    state_next = (stat.op == OP_ADD) ? FSM_FREE : FSM_RESULT;
                end
            end
            FSM_FREE: begin
                cmd.sel_free = 1'b1;
                state_next   = FSM_RESULT;
            end
            FSM_CURSOR: begin
                cmd.sel_cursor = 1'b1;
                state_next     = FSM_RESULT;
            end
            // member reads, compared in the cycle after each issue
            FSM_MSCAN: begin
                cmd.mem_check = 1'b1;
                if (stat.mem_hit) begin
                    state_next = FSM_RESULT;
                end else begin
                    cmd.mem_issue = 1'b1;
                    if (stat.issue_last) state_next = FSM_MTAIL;
                end
            end
            FSM_MTAIL: begin
                cmd.mem_check = 1'b1;
                state_next    = FSM_RESULT;
            end
            FSM_RSCAN: begin
                cmd.mem_check = 1'b1;
                if (stat.mem_hit) begin
                    state_next = FSM_RESULT;
                end else begin
                    cmd.mem_issue = 1'b1;
                    if (stat.issue_last) state_next = FSM_RTAIL;
                end
            end
            FSM_RTAIL: begin
                cmd.mem_check = 1'b1;
                state_next    = FSM_RESULT;
            end
            FSM_RESULT: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

endmodule

// ===== rtl/job_table_engine_top.sv =====
// Job table engine: a table of JOBS job slots with lookup by job id or member id and a
// done-queue counter. One item is taken at a time. Enqueue done and unknown operations go
// straight to the result, and add member selects the add cursor slot first. Find by id,
// delete and add scan the slot table one slot per cycle, add then selects the free slot, and
// remove member then reads the members of the matched slot one member per cycle; find by
// member reads the member store slot by slot through its single read port. A result that
// is still waiting in the output register holds off the load of the next one. The next
// item is accepted on the cycle after the result is loaded, even while that result waits
// to be taken.
module job_table_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // job_id[15:0], group_id[37:16], member_id[59:38], proc_count[63:60], init_state[65:64]
    input  logic [jte_pkg::S_DATA_W-1:0] s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found_job_id[15:0], slot_index[19:16], found_group[41:20], found_count[45:42],
    // found_remaining[49:46], found_state[51:50], done_count[56:52]
    output logic [jte_pkg::M_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser
);
    import jte_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [ID_W-1:0]   out_job_id;
    logic [SLOT_O-1:0] out_slot;
    logic [GRP_W-1:0]  out_group;
    logic [CNT_W-1:0]  out_count;
    logic [CNT_W-1:0]  out_remaining;
    logic [ST_W-1:0]   out_state;
    logic [DONE_W-1:0] out_done;

    jte_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    jte_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_op         (s_axis_tuser),
        .in_job_id     (s_axis_tdata[15:0]),
        .in_group_id   (s_axis_tdata[37:16]),
        .in_member_id  (s_axis_tdata[59:38]),
        .in_proc_count (s_axis_tdata[63:60]),
        .in_init_state (s_axis_tdata[65:64]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_status    (m_axis_tuser),
        .out_job_id    (out_job_id),
        .out_slot      (out_slot),
        .out_group     (out_group),
        .out_count     (out_count),
        .out_remaining (out_remaining),
        .out_state     (out_state),
        .out_done      (out_done)
    );

    assign m_axis_tdata = {7'd0, out_done, out_state, out_remaining, out_count,
                           out_group, out_slot, out_job_id};

endmodule

// ===== rtl/jte_checker.sv =====
// Port-level checker for the job table engine, bound to the top level.
// Depends on jte_pkg.
module jte_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import jte_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while busy");

    // failed items carry only status and done count
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[51:0] == '0))
        else $error("failed result carries data");

    // done count never passes the queue depth
    a_done_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (int'(m_axis_tdata[56:52]) <= JOBS))
        else $error("done count out of range");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind job_table_engine_top jte_checker u_jte_checker (.*);
